### hw/rtl/ltm_pkg.sv
// ----------------------------------------------------------------------------
// ltm_pkg
// Types and constants for the link loss / ETT metric unit.
// ----------------------------------------------------------------------------
package ltm_pkg;

	localparam int unsigned COST_MAXIMUM = 65536;
	localparam int unsigned CMIN         = COST_MAXIMUM / 16;
	localparam int          CMIN_W       = $clog2(CMIN + 1);
	localparam int          METRIC_W     = $clog2(COST_MAXIMUM + 1);

	localparam int WIN_W      = 7;
	localparam int SEQ_W      = 16;
	localparam int RECV_W     = 16;
	localparam int EXP_W      = 24;
	localparam int MISSED_W   = 16;
	localparam int IVL_W      = 24;
	localparam int RATE_W     = 40;
	localparam int RECV_SUM_W = 23;
	localparam int EXP_SUM_W  = 32;
	localparam int PROD_W     = 47;
	localparam int GAP_W      = 8;

	localparam int DIV_NUM_W = 71;
	localparam int DIV_DEN_W = 31;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	localparam int RATE_DIV_W = 9;
	localparam logic [RATE_W-1:0]     SPEED_UNIT   = 40'd1048576;
	localparam logic [RATE_W-1:0]     SPEED_TOP    = 40'd268435456;
	localparam logic [RATE_DIV_W-1:0] RATE_DIV_TOP = 9'd256;

	localparam logic [SEQ_W-1:0]     GAP_LIMIT  = 16'd255;
	localparam logic [RECV_W-1:0]    RECV_MAX   = 16'hFFFF;
	localparam logic [EXP_W-1:0]     EXP_MAX    = 24'hFFFFFF;
	localparam logic [MISSED_W-1:0]  MISSED_MAX = 16'hFFFF;
	localparam logic [EXP_SUM_W-1:0] SUM_MAX    = 32'hFFFFFFFF;

	localparam logic [IVL_W-1:0] SAMPLE_INTERVAL_RST = 24'd1000;
	localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST   = 7'd64;
	localparam logic [WIN_W-1:0] START_WINDOW_RST    = 7'd4;

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd0;
	localparam logic [1:0] REG_WINDOW_LENGTH   = 2'd1;
	localparam logic [1:0] REG_START_WINDOW    = 2'd2;

	typedef enum logic [1:0] {
		KIND_PKT        = 2'd0,
		KIND_TICK       = 2'd1,
		KIND_HELLO_LOST = 2'd2,
		KIND_LINK_CHG   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PKT_WR,
		ST_SUM,
		ST_INF_MUL,
		ST_INF_MUL_LO,
		ST_INF_MUL_HI,
		ST_INF_DIV,
		ST_MET_CHK,
		ST_MET_MUL,
		ST_MET_DIV,
		ST_RATE_DIV,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic [RECV_W-1:0] recv;
		logic [EXP_W-1:0]  expd;
	} bucket_t;

	typedef struct packed {
		logic [IVL_W-1:0] sample_interval_ms;
		logic [WIN_W-1:0] window_length;
		logic [WIN_W-1:0] start_window_length;
	} cfg_t;

endpackage

### hw/rtl/ltm_bucket_mem.sv
// ----------------------------------------------------------------------------
// ltm_bucket_mem
// Bucket ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ltm_bucket_mem
	import ltm_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  bucket_t       wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output bucket_t       rdata
);

	bucket_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/ltm_div.sv
// ----------------------------------------------------------------------------
// ltm_div
// Restoring divider, one quotient bit per cycle, shared by all divisions of a tick.
// ----------------------------------------------------------------------------
module ltm_div
	import ltm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;
	logic [DIV_DEN_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[DIV_NUM_W-1]};
		diff    = trial - {1'b0, den_q};
		ge      = trial >= {1'b0, den_q};
		rem_nxt = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### hw/rtl/ltm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ltm_cfg_regs
// APB register file: sample interval, window length, start window length.
// ----------------------------------------------------------------------------
module ltm_cfg_regs
	import ltm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval_ms  <= SAMPLE_INTERVAL_RST;
			cfg_q.window_length       <= WINDOW_LENGTH_RST;
			cfg_q.start_window_length <= START_WINDOW_RST;
		end else if (wr) begin
			unique case (idx)
				REG_SAMPLE_INTERVAL: cfg_q.sample_interval_ms  <= pwdata[IVL_W-1:0];
				REG_WINDOW_LENGTH:   cfg_q.window_length       <= pwdata[WIN_W-1:0];
				REG_START_WINDOW:    cfg_q.start_window_length <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SAMPLE_INTERVAL: prdata = 32'(cfg_q.sample_interval_ms);
			REG_WINDOW_LENGTH:   prdata = 32'(cfg_q.window_length);
			REG_START_WINDOW:    prdata = 32'(cfg_q.start_window_length);
			default:             prdata = '0;
		endcase
	end

endmodule

### hw/rtl/link_loss_ett_metric_unit.sv
// ----------------------------------------------------------------------------
// link_loss_ett_metric_unit
// Sliding-window ETX/ETT link metric over a ring of bucket counters.
// ----------------------------------------------------------------------------
// Packet word: read bucket, then write back; the first packet is written directly.
// Hello-lost and link-changed words end in idle. Tick: sum n buckets (one memory
// read per cycle), inflate with missed hellos (multiply, divide), metric multiply
// and divide (skipped at maximum), rate divide, emit; one shared divider.
// One word in flight at a time; done pulses once per tick after the first packet
// and cannot be held off. Reset: clearing pass over every bucket, busy high.
// ----------------------------------------------------------------------------
module link_loss_ett_metric_unit
	import ltm_pkg::*;
#(
	parameter int BUCKET_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [SEQ_W-1:0]   seq_number,
	input  logic [RATE_W-1:0]  link_bitrate,
	input  logic [IVL_W-1:0]   hello_interval_ms,
	output logic               done,
	output logic [16:0]        metric,
	output logic [31:0]        received_sum,
	output logic [31:0]        expected_sum,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW     = $clog2(BUCKET_DEPTH);
	localparam int CW     = ((AW > WIN_W) ? AW : WIN_W) + 1;
	localparam int CMUL_W = CMIN_W + EXP_SUM_W;

	cfg_t cfg;

	st_t state_q, state_d;

	logic                 started_q;
	logic [AW-1:0]        slot_q;
	logic [WIN_W-1:0]     cur_win_q;
	logic [SEQ_W-1:0]     last_seq_q;
	logic [MISSED_W-1:0]  missed_q;
	logic [IVL_W-1:0]     hello_q;
	logic [AW-1:0]        clr_addr_q;
	logic [WIN_W-1:0]     rd_cnt_q;
	logic                 rd_pend_s1;
	logic                 div_run_q;

	logic [GAP_W-1:0]      gap_q;
	logic [WIN_W-1:0]      n_q;
	logic [WIN_W-1:0]      ring_q;
	logic [RATE_DIV_W-1:0] rate_div_q;
	logic [RECV_SUM_W-1:0] acc_recv_q;
	logic [EXP_SUM_W-1:0]  acc_exp_q;
	logic [PROD_W-1:0]     prod_q;
	logic [DIV_DEN_W-1:0]  divisor_q;
	logic [DIV_NUM_W-1:0]  ph_q;
	logic [METRIC_W-1:0]   metric_q;

	logic                 accept;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	bucket_t              mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	bucket_t              mem_rdata;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;

	logic [WIN_W-1:0]      ring_c;
	logic [WIN_W-1:0]      new_win_c;
	logic [WIN_W-1:0]      n_c;
	logic [SEQ_W-1:0]      gap_raw;
	logic [GAP_W-1:0]      gap_c;
	logic [RATE_DIV_W-1:0] rate_div_c;
	logic [CW-1:0]         slot_inc;
	logic [AW-1:0]         slot_nxt;
	logic [RECV_W-1:0]     recv_upd;
	logic [EXP_W:0]        exp_sum;
	logic [EXP_W-1:0]      exp_upd;
	logic [IVL_W-1:0]      ivl_c;
	logic [DIV_DEN_W-1:0]  ivl_ring;
	logic [PROD_W-1:0]     prod_c;
	logic [47:0]           pp_lo;
	logic [46:0]           pp_hi;
	logic [CMUL_W-1:0]     cmul;
	logic [EXP_SUM_W:0]    inf_sum;
	logic                  met_max;

	ltm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ltm_bucket_mem #(
		.DEPTH (BUCKET_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ltm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		ring_c = cfg.window_length;
		if (ring_c == '0) begin
			ring_c = WIN_W'(1);
		end
		if (CW'(ring_c) > CW'(BUCKET_DEPTH)) begin
			ring_c = WIN_W'(BUCKET_DEPTH);
		end
		new_win_c = (cur_win_q < ring_c) ? cur_win_q + 1'b1 : cur_win_q;
		n_c       = (new_win_c < ring_c) ? new_win_c : ring_c;

		gap_raw = seq_number - last_seq_q;
		gap_c   = (gap_raw > GAP_LIMIT) ? GAP_W'(1) : gap_raw[GAP_W-1:0];

		if (link_bitrate > SPEED_TOP) begin
			rate_div_c = RATE_DIV_TOP;
		end else if (link_bitrate > SPEED_UNIT) begin
			rate_div_c = link_bitrate[28:20];
		end else begin
			rate_div_c = RATE_DIV_W'(1);
		end

		slot_inc = CW'(slot_q) + 1'b1;
		slot_nxt = (slot_inc >= CW'(ring_q)) ? '0 : AW'(slot_inc);

		recv_upd = (mem_rdata.recv == RECV_MAX) ? RECV_MAX : mem_rdata.recv + 1'b1;
		exp_sum  = {1'b0, mem_rdata.expd} + (EXP_W + 1)'(gap_q);
		exp_upd  = exp_sum[EXP_W] ? EXP_MAX : exp_sum[EXP_W-1:0];

		ivl_c    = (cfg.sample_interval_ms == '0) ? IVL_W'(1) : cfg.sample_interval_ms;
		ivl_ring = {7'b0, ivl_c} * {24'b0, ring_q};
		prod_c   = {16'b0, acc_exp_q[30:0]} * {31'b0, missed_q};
		pp_lo    = {24'b0, prod_q[23:0]} * {24'b0, hello_q};
		pp_hi    = {24'b0, prod_q[46:24]} * {23'b0, hello_q};
		cmul     = {{CMIN_W{1'b0}}, acc_exp_q} * CMUL_W'(CMIN);
		inf_sum  = {1'b0, acc_exp_q} + {1'b0, div_quo[EXP_SUM_W-1:0]};

		met_max = (acc_recv_q == '0) || (EXP_SUM_W'({acc_recv_q, 4'b0000}) < acc_exp_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(BUCKET_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (kind_t'(kind))
						KIND_PKT:  state_d = started_q ? ST_PKT_WR : ST_IDLE;
						KIND_TICK: state_d = started_q ? ST_SUM : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_PKT_WR: state_d = ST_IDLE;
			ST_SUM: begin
				if (rd_cnt_q == n_q && !rd_pend_s1) begin
					state_d = (missed_q != '0) ? ST_INF_MUL : ST_MET_CHK;
				end
			end
			ST_INF_MUL:    state_d = ST_INF_MUL_LO;
			ST_INF_MUL_LO: state_d = ST_INF_MUL_HI;
			ST_INF_MUL_HI: state_d = ST_INF_DIV;
			ST_INF_DIV: begin
				if (div_done) begin
					state_d = ST_MET_CHK;
				end
			end
			ST_MET_CHK: state_d = met_max ? ST_RATE_DIV : ST_MET_MUL;
			ST_MET_MUL: state_d = ST_MET_DIV;
			ST_MET_DIV: begin
				if (div_done) begin
					state_d = ST_RATE_DIV;
				end
			end
			ST_RATE_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		accept    = start && (state_q == ST_IDLE);
		done      = (state_q == ST_EMIT);
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{recv: '0, expd: '0};
		mem_re    = 1'b0;
		mem_raddr = slot_q;
		div_start = 1'b0;
		div_num   = ph_q;
		div_den   = divisor_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '{recv: '0, expd: EXP_W'(1)};
			end
			ST_IDLE: begin
				if (accept && kind_t'(kind) == KIND_PKT) begin
					if (started_q) begin
						mem_re = 1'b1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = '{recv: RECV_W'(1), expd: EXP_W'(1)};
					end
				end
			end
			ST_PKT_WR: begin
				mem_we    = 1'b1;
				mem_wdata = '{recv: recv_upd, expd: exp_upd};
			end
			ST_SUM: begin
				mem_re    = (rd_cnt_q < n_q);
				mem_raddr = AW'(rd_cnt_q);
			end
			ST_INF_DIV: begin
				div_start = !div_run_q;
			end
			ST_MET_DIV: begin
				div_start = !div_run_q;
				div_den   = DIV_DEN_W'(acc_recv_q);
			end
			ST_RATE_DIV: begin
				div_start = !div_run_q;
				div_num   = DIV_NUM_W'(metric_q);
				div_den   = DIV_DEN_W'(rate_div_q);
			end
			ST_EMIT: begin
				mem_we    = 1'b1;
				mem_waddr = slot_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			started_q  <= 1'b0;
			slot_q     <= '0;
			cur_win_q  <= START_WINDOW_RST;
			last_seq_q <= '0;
			missed_q   <= '0;
			hello_q    <= '0;
			clr_addr_q <= '0;
			rd_cnt_q   <= '0;
			rd_pend_s1 <= 1'b0;
			div_run_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= mem_re && (state_q == ST_SUM);
			if (div_start) begin
				div_run_q <= 1'b1;
			end else if (div_done) begin
				div_run_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: clr_addr_q <= clr_addr_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						case (kind_t'(kind))
							KIND_PKT: begin
								last_seq_q <= seq_number;
								if (!started_q) begin
									started_q <= 1'b1;
									slot_q    <= '0;
									cur_win_q <= cfg.start_window_length;
								end
							end
							KIND_TICK: begin
								if (started_q) begin
									cur_win_q <= new_win_c;
									rd_cnt_q  <= '0;
								end
							end
							KIND_HELLO_LOST: begin
								if (started_q && missed_q != MISSED_MAX) begin
									missed_q <= missed_q + 1'b1;
								end
							end
							default: begin
								hello_q  <= hello_interval_ms;
								missed_q <= '0;
							end
						endcase
					end
				end
				ST_SUM: begin
					if (mem_re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				ST_EMIT: slot_q <= slot_nxt;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				gap_q      <= gap_c;
				n_q        <= n_c;
				ring_q     <= ring_c;
				rate_div_q <= rate_div_c;
				acc_recv_q <= '0;
				acc_exp_q  <= '0;
			end
			ST_SUM: begin
				if (rd_pend_s1) begin
					acc_recv_q <= acc_recv_q + RECV_SUM_W'(mem_rdata.recv);
					acc_exp_q  <= acc_exp_q + EXP_SUM_W'(mem_rdata.expd);
				end
			end
			ST_INF_MUL: begin
				prod_q    <= prod_c;
				divisor_q <= ivl_ring;
			end
			ST_INF_MUL_LO: ph_q <= DIV_NUM_W'(pp_lo);
			ST_INF_MUL_HI: ph_q <= ph_q + DIV_NUM_W'({pp_hi, 24'b0});
			ST_INF_DIV: begin
				if (div_done) begin
					if (inf_sum[EXP_SUM_W] || (div_quo[DIV_NUM_W-1:EXP_SUM_W] != '0)) begin
						acc_exp_q <= SUM_MAX;
					end else begin
						acc_exp_q <= inf_sum[EXP_SUM_W-1:0];
					end
				end
			end
			ST_MET_CHK: begin
				if (met_max) begin
					metric_q <= METRIC_W'(COST_MAXIMUM);
				end
			end
			ST_MET_MUL: ph_q <= DIV_NUM_W'(cmul);
			ST_MET_DIV, ST_RATE_DIV: begin
				if (div_done) begin
					metric_q <= METRIC_W'(div_quo);
				end
			end
			default: ;
		endcase
	end

	assign metric       = 17'(metric_q);
	assign received_sum = 32'(acc_recv_q);
	assign expected_sum = acc_exp_q;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link loss / ETT metric unit. Words are issued
// on the start/busy port in random bursts and gaps; each accepted word runs
// through a local model of the bucket ring, and every done strobe is checked
// against the oldest predicted metric word. A directed table covers first
// packet, sequence wrap, repeats and large gaps, ticks before start-up and
// rate extremes. Random phases then walk register settings out to their
// limits (zero interval, short and oversized rings), and one phase drives
// the expected sum into saturation through missed-hello inflation.
// Registers are written and read back over APB when idle.
// ----------------------------------------------------------------------------
module tb_top;
	import ltm_pkg::*;

	localparam int DEPTH       = 64;
	localparam int LATENCY_PAD = 300;

	typedef struct packed {
		kind_t             kind;
		logic [SEQ_W-1:0]  seq;
		logic [RATE_W-1:0] rate;
		logic [IVL_W-1:0]  hello;
	} link_word_t;

	typedef struct packed {
		logic [16:0] metric;
		logic [31:0] rx_sum;
		logic [31:0] ex_sum;
	} metric_word_t;

	typedef struct {
		link_word_t   w;
		bit           typed;
		metric_word_t want;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic [SEQ_W-1:0]   seq_number;
	logic [RATE_W-1:0]  link_bitrate;
	logic [IVL_W-1:0]   hello_interval_ms;
	logic               done;
	logic [16:0]        metric;
	logic [31:0]        received_sum;
	logic [31:0]        expected_sum;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	logic [RECV_W-1:0]   rx_bucket [DEPTH];
	logic [EXP_W-1:0]    ex_bucket [DEPTH];
	int unsigned         head_slot;
	bit                  link_up;
	int unsigned         win_now;
	logic [SEQ_W-1:0]    prev_seq;
	logic [MISSED_W-1:0] lost_hellos;
	logic [IVL_W-1:0]    hello_ms;
	logic [IVL_W-1:0]    cfg_sample_ms;
	logic [WIN_W-1:0]    cfg_win;
	logic [WIN_W-1:0]    cfg_start_win;

	metric_word_t     metric_due [$];
	metric_word_t     due_head;
	plan_row_t        dir_plan [$];
	logic [SEQ_W-1:0] seq_cursor;
	int unsigned      fail_count = 0;

	link_loss_ett_metric_unit #(
		.BUCKET_DEPTH(DEPTH)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.seq_number       (seq_number),
		.link_bitrate     (link_bitrate),
		.hello_interval_ms(hello_interval_ms),
		.done             (done),
		.metric           (metric),
		.received_sum     (received_sum),
		.expected_sum     (expected_sum),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#16000000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic link_word_t word_of(input kind_t k, input logic [SEQ_W-1:0] s,
			input logic [RATE_W-1:0] r, input logic [IVL_W-1:0] h);
		link_word_t w;
		w.kind  = k;
		w.seq   = s;
		w.rate  = r;
		w.hello = h;
		return w;
	endfunction

	function automatic bit advance_link_metric(input link_word_t w, output metric_word_t res);
		logic [SEQ_W-1:0] gap;
		logic [31:0]      ex_acc;
		int unsigned      ring;
		int unsigned      n;
		logic [63:0]      rx, ex, m, dv, p, pq, pr, extra, h;
		res = '0;
		case (w.kind)
		KIND_PKT: begin
			if (!link_up) begin
				link_up      = 1'b1;
				head_slot    = 0;
				rx_bucket[0] = 1;
				ex_bucket[0] = 1;
				prev_seq     = w.seq;
				win_now      = cfg_start_win;
			end else begin
				gap = w.seq - prev_seq;
				if (gap > GAP_LIMIT)
					gap = 1;
				if (rx_bucket[head_slot] != RECV_MAX)
					rx_bucket[head_slot] += 1'b1;
				ex_acc = ex_bucket[head_slot] + gap;
				ex_bucket[head_slot] = (ex_acc > EXP_MAX) ? EXP_MAX : ex_acc[EXP_W-1:0];
				prev_seq = w.seq;
			end
			return 1'b0;
		end
		KIND_HELLO_LOST: begin
			if (link_up && lost_hellos != MISSED_MAX)
				lost_hellos += 1'b1;
			return 1'b0;
		end
		KIND_LINK_CHG: begin
			hello_ms    = w.hello;
			lost_hellos = '0;
			return 1'b0;
		end
		default: ;
		endcase

		if (!link_up)
			return 1'b0;
		ring = cfg_win;
		if (ring < 1)
			ring = 1;
		if (ring > DEPTH)
			ring = DEPTH;
		if (win_now < ring)
			win_now++;
		n  = (win_now < ring) ? win_now : ring;
		rx = '0;
		ex = '0;
		for (int i = 0; i < n; i++) begin
			rx += rx_bucket[i];
			ex += ex_bucket[i];
		end
		if (lost_hellos != 0) begin
			dv = cfg_sample_ms;
			if (dv == 0)
				dv = 1;
			dv = dv * ring;
			p  = ex * lost_hellos;
			h  = hello_ms;
			pq = p / dv;
			pr = p % dv;
			if (h != 0 && pq > SUM_MAX / h)
				extra = SUM_MAX;
			else
				extra = pq * h + (pr * h) / dv;
			ex = ex + extra;
			if (ex > SUM_MAX)
				ex = SUM_MAX;
		end
		if (rx == 0 || rx * 16 < ex)
			m = COST_MAXIMUM;
		else
			m = (CMIN * ex) / rx;
		if (w.rate > SPEED_TOP)
			m = m / RATE_DIV_TOP;
		else if (w.rate > SPEED_UNIT)
			m = m / (w.rate / SPEED_UNIT);
		res.metric = m[16:0];
		res.rx_sum = rx[31:0];
		res.ex_sum = ex[31:0];
		head_slot++;
		if (head_slot >= ring)
			head_slot = 0;
		rx_bucket[head_slot] = '0;
		ex_bucket[head_slot] = '0;
		return 1'b1;
	endfunction

	function automatic link_word_t random_word();
		link_word_t  w;
		logic [63:0] bits;
		int unsigned pick;
		bits    = {$urandom(), $urandom()};
		w.rate  = bits[RATE_W-1:0];
		w.hello = IVL_W'($urandom());
		w.seq   = SEQ_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 62)
			w.kind = KIND_PKT;
		else if (pick < 78)
			w.kind = KIND_TICK;
		else if (pick < 90)
			w.kind = KIND_HELLO_LOST;
		else
			w.kind = KIND_LINK_CHG;
		case (w.kind)
		KIND_PKT: begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				w.seq = seq_cursor + SEQ_W'($urandom_range(1, 3));
			else if (pick < 78)
				w.seq = seq_cursor;
			else if (pick < 82)
				w.seq = seq_cursor + 16'd255;
			else if (pick < 86)
				w.seq = seq_cursor + 16'd256;
			else if (pick < 90)
				w.seq = seq_cursor + SEQ_W'($urandom_range(4, 254));
			seq_cursor = w.seq;
		end
		KIND_TICK: begin
			case ($urandom_range(0, 5))
			0: w.rate = '0;
			1: w.rate = RATE_W'($urandom_range(1, 1048576));
			2: w.rate = SPEED_UNIT + RATE_W'($urandom_range(0, 1));
			3: w.rate = SPEED_UNIT * RATE_W'($urandom_range(2, 256))
				+ RATE_W'($urandom_range(0, 1023));
			4: w.rate = SPEED_TOP + RATE_W'($urandom_range(0, 1));
			default: ;
			endcase
		end
		KIND_LINK_CHG: begin
			case ($urandom_range(0, 2))
			0: w.hello = '0;
			1: w.hello = IVL_W'($urandom_range(1, 2000));
			default: ;
			endcase
		end
		default: ;
		endcase
		return w;
	endfunction

	task automatic issue_word(input link_word_t w, input bit typed, input metric_word_t want);
		metric_word_t got;
		kind              <= w.kind;
		seq_number        <= w.seq;
		link_bitrate      <= w.rate;
		hello_interval_ms <= w.hello;
		start             <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (advance_link_metric(w, got))
			metric_due.push_back(typed ? want : got);
	endtask

	task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
		REG_SAMPLE_INTERVAL: begin
			cfg_sample_ms = value[IVL_W-1:0];
			want = {8'd0, value[IVL_W-1:0]};
		end
		REG_WINDOW_LENGTH: begin
			cfg_win = value[WIN_W-1:0];
			want = {25'd0, value[WIN_W-1:0]};
		end
		REG_START_WINDOW: begin
			cfg_start_win = value[WIN_W-1:0];
			want = {25'd0, value[WIN_W-1:0]};
		end
		default: want = value;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (readback !== want)
			note_failure($sformatf("register %0d readback: expected %h, got %h",
				idx, want, readback));
	endtask

	task automatic drain_metrics();
		while (metric_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		int unsigned pick;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				issue_word(random_word(), 1'b0, '0);
				sent++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 15)
				gap = 0;
			else if (pick < 55)
				gap = $urandom_range(1, 4);
			else if (pick < 85)
				gap = $urandom_range(5, 40);
			else
				gap = $urandom_range(41, 320);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	task automatic run_saturation();
		repeat (60) begin
			seq_cursor += 16'd255;
			issue_word(word_of(KIND_PKT, seq_cursor, '0, '0), 1'b0, '0);
		end
		issue_word(word_of(KIND_TICK, '0, '0, '0), 1'b0, '0);
		issue_word(word_of(KIND_LINK_CHG, '0, '0, 24'hFFFFFF), 1'b0, '0);
		repeat (40)
			issue_word(word_of(KIND_HELLO_LOST, '0, '0, '0), 1'b0, '0);
		issue_word(word_of(KIND_TICK, '0, SPEED_UNIT, '0), 1'b0, '0);
		issue_word(word_of(KIND_TICK, '0, 40'hFF_FFFF_FFFF, '0), 1'b0, '0);
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (metric_due.size() == 0) begin
				note_failure($sformatf("unexpected metric word: metric=%0d rx=%0d ex=%0d",
					metric, received_sum, expected_sum));
			end else begin
				due_head = metric_due.pop_front();
				if (metric !== due_head.metric || received_sum !== due_head.rx_sum
						|| expected_sum !== due_head.ex_sum)
					note_failure($sformatf({"metric word: expected metric=%0d rx=%0d ex=%0d,",
						" got metric=%0d rx=%0d ex=%0d"}, due_head.metric, due_head.rx_sum,
						due_head.ex_sum, metric, received_sum, expected_sum));
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		start             <= 1'b0;
		kind              <= KIND_PKT;
		seq_number        <= '0;
		link_bitrate      <= '0;
		hello_interval_ms <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;

		for (int i = 0; i < DEPTH; i++) begin
			rx_bucket[i] = '0;
			ex_bucket[i] = 1;
		end
		head_slot     = 0;
		link_up       = 1'b0;
		win_now       = START_WINDOW_RST;
		prev_seq      = '0;
		lost_hellos   = '0;
		hello_ms      = '0;
		cfg_sample_ms = SAMPLE_INTERVAL_RST;
		cfg_win       = WINDOW_LENGTH_RST;
		cfg_start_win = START_WINDOW_RST;
		seq_cursor    = '0;

		dir_plan.push_back('{word_of(KIND_TICK, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_HELLO_LOST, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'hFFFF, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h0000, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h0000, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h00FF, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h01FF, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_TICK, '0, '0, '0), 1'b1,
			{17'd65536, 32'd5, 32'd262}});
		dir_plan.push_back('{word_of(KIND_TICK, '0, 40'hFF_FFFF_FFFF, '0), 1'b1,
			{17'd256, 32'd5, 32'd262}});
		dir_plan.push_back('{word_of(KIND_LINK_CHG, '0, '0, 24'hFFFFFF), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h0200, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h0201, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h0202, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_HELLO_LOST, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_HELLO_LOST, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_TICK, '0, SPEED_TOP, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_LINK_CHG, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_HELLO_LOST, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_TICK, '0, SPEED_UNIT, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_PKT, 16'h0203, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_TICK, '0, 40'd3145728, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_LINK_CHG, '0, '0, 24'd500), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_HELLO_LOST, '0, '0, '0), 1'b0, '0});
		dir_plan.push_back('{word_of(KIND_TICK, '0, 40'd1048577, '0), 1'b0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		while (busy)
			@(posedge clk);

		foreach (dir_plan[i]) begin
			issue_word(dir_plan[i].w, dir_plan[i].typed, dir_plan[i].want);
			if ($urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		start <= 1'b0;
		seq_cursor = 16'h0203;

		for (int p = 0; p < 8; p++) begin
			drain_metrics();
			case (p)
			0: begin
				program_reg(REG_SAMPLE_INTERVAL, 32'd100);
				program_reg(REG_WINDOW_LENGTH, 32'd64);
				program_reg(REG_START_WINDOW, 32'd1);
			end
			1: begin
				program_reg(REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF);
				program_reg(REG_WINDOW_LENGTH, 32'd2);
				program_reg(REG_START_WINDOW, 32'd64);
			end
			2: begin
				program_reg(REG_SAMPLE_INTERVAL, 32'd0);
				program_reg(REG_WINDOW_LENGTH, 32'd0);
				program_reg(REG_START_WINDOW, 32'd0);
			end
			3: begin
				program_reg(REG_SAMPLE_INTERVAL, 32'd1);
				program_reg(REG_WINDOW_LENGTH, 32'hFFFF_FF7F);
				program_reg(REG_START_WINDOW, 32'd127);
			end
			4: begin
				program_reg(REG_SAMPLE_INTERVAL, 32'd1000);
				program_reg(REG_WINDOW_LENGTH, 32'd5);
				program_reg(REG_START_WINDOW, 32'd3);
			end
			6: begin
				program_reg(REG_SAMPLE_INTERVAL, 32'd100);
				program_reg(REG_WINDOW_LENGTH, 32'd2);
				program_reg(REG_START_WINDOW, 32'd2);
			end
			default: begin
				program_reg(REG_SAMPLE_INTERVAL, $urandom());
				program_reg(REG_WINDOW_LENGTH, $urandom());
				program_reg(REG_START_WINDOW, $urandom());
			end
			endcase
			if (p == 6)
				run_saturation();
			else
				run_random(130);
		end

		drain_metrics();
		if (metric_due.size() != 0)
			note_failure($sformatf("%0d metric words never arrived", metric_due.size()));
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
